/* rtl/twq_pkg.sv */
// twq_pkg: shared types and constants of the ticketed wait queue.
// Holds the transaction structs, command and status codes and the FSM state type.
// No dependencies; ticketed_wait_queue imports it.
`timescale 1ns / 1ps

package twq_pkg;

   // Field widths fixed by the transaction format.
   localparam int TICKET_WIDTH  = 16;
   localparam int PARTY_WIDTH   = 8;
   localparam int CMD_WIDTH     = 3;
   localparam int STATUS_WIDTH  = 3;
   localparam int TEAMS_WIDTH   = 7;
   localparam int PEOPLE_WIDTH  = 14;

   // Default queue depth.
   localparam int DEPTH_DEFAULT = 64;

   // Command codes.
   localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_QUERY   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CANCEL  = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DELAY   = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_SERVE   = 3'd4;

   // Status codes.
   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_AT_TAIL   = 3'd4;

   // Request transaction.
   typedef struct packed {
      logic [CMD_WIDTH-1:0]    cmd;
      logic [PARTY_WIDTH-1:0]  party_size;
      logic [TICKET_WIDTH-1:0] ticket;
   } twq_req_type;

   // Response transaction.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [TICKET_WIDTH-1:0] ticket_out;
      logic [PARTY_WIDTH-1:0]  party_out;
      logic [TEAMS_WIDTH-1:0]  teams_ahead;
      logic [PEOPLE_WIDTH-1:0] people_ahead;
   } twq_rsp_type;

   // One queue entry as held in the memory.
   typedef struct packed {
      logic [TICKET_WIDTH-1:0] ticket;
      logic [PARTY_WIDTH-1:0]  party;
   } twq_entry_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_SWAP,
      S_SWAP2
   } twq_state_type;

endpackage

/* rtl/twq_ram.sv */
// twq_ram: generic single-port-write, single-port-read RAM with registered read.
// Parameterised by word width and depth; no dependencies.
`timescale 1ns / 1ps

module twq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/ticketed_wait_queue.sv */
// ticketed_wait_queue: ordered queue of tickets with enqueue, query, cancel, delay, serve.
// Depends on twq_pkg and on twq_ram, which holds the entries in queue order.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_data      in         taken when start and not busy
//   response  rsp_valid, rsp_data        out        one-cycle strobe, cannot be stalled
//
// Enqueue and unused commands are answered from idle; the response follows on the next cycle.
// Query, cancel, delay and serve walk the entry memory one entry per cycle from the head;
// query stops at the match, cancel and serve then move up each entry behind the removed
// one, and delay swaps the match with the entry behind it unless it is at the tail.
// The single read and write port of the entry memory sets this pace.
// Reset clears the count and the ticket counter; memory contents need no clearing.
`timescale 1ns / 1ps

module ticketed_wait_queue #(
   parameter int DEPTH = twq_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  twq_pkg::twq_req_type  req_data,
   output logic                  rsp_valid,
   output twq_pkg::twq_rsp_type  rsp_data
);

   import twq_pkg::*;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = PARTY_WIDTH + IDX_W;
   localparam int ENTRY_W = $bits(twq_entry_type);

   // Registers and their next values.
   twq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [TICKET_WIDTH-1:0]  last_ticket_ff, last_ticket_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   twq_entry_type            hold_ff, hold_in;
   twq_req_type              req_ff, req_in;
   twq_rsp_type              rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Memory port signals.
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   twq_entry_type            ram_wr_data;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_raw;
   twq_entry_type            rd_entry;

   // Position arithmetic around the scan index.
   logic [CNT_W-1:0]         scan_p1;
   logic [CNT_W-1:0]         scan_p2;
   logic                     accept;
   logic                     hit;
   logic                     at_last;

   assign rd_entry = twq_entry_type'(ram_rd_raw);
   assign scan_p1  = CNT_W'(scan_ff) + CNT_W'(1);
   assign scan_p2  = CNT_W'(scan_ff) + CNT_W'(2);
   assign accept   = start && (state_ff == S_IDLE);
   assign hit      = (req_ff.cmd == CMD_SERVE) || (rd_entry.ticket == req_ff.ticket);
   assign at_last  = (scan_p1 == cnt_ff);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   twq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         last_ticket_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         last_ticket_ff <= last_ticket_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      sum_ff  <= sum_in;
      hold_ff <= hold_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   // Next state, memory accesses and response.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      last_ticket_in = last_ticket_ff;
      scan_in        = scan_ff;
      sum_in         = sum_ff;
      hold_in        = hold_ff;
      req_in         = req_ff;
      rsp_in         = '0;
      rsp_valid_in   = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = scan_ff;
      ram_wr_data    = rd_entry;
      ram_rd_addr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            // The head entry is always read, ready for a scan that may start.
            ram_rd_addr = '0;
            scan_in     = '0;
            sum_in      = '0;
            if (accept) begin
               req_in = req_data;
               unique case (req_data.cmd) inside
                  CMD_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff == CNT_W'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        last_ticket_in     = last_ticket_ff + TICKET_WIDTH'(1);
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = cnt_ff[IDX_W-1:0];
                        ram_wr_data.ticket = last_ticket_ff + TICKET_WIDTH'(1);
                        ram_wr_data.party  = req_data.party_size;
                        cnt_in             = cnt_ff + CNT_W'(1);
                        rsp_in.ticket_out  = last_ticket_ff + TICKET_WIDTH'(1);
                     end
                  end
                  CMD_QUERY, CMD_CANCEL, CMD_DELAY: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_SERVE: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     // Unused command: plain acknowledgement.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            // Read data holds entry scan_ff; the next entry is fetched meanwhile.
            ram_rd_addr = scan_p1[IDX_W-1:0];
            if (hit) begin
               unique case (req_ff.cmd)
                  CMD_QUERY: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.teams_ahead  = TEAMS_WIDTH'(scan_ff);
                     rsp_in.people_ahead = PEOPLE_WIDTH'(sum_ff);
                     state_in            = S_IDLE;
                  end
                  CMD_DELAY: begin
                     if (at_last) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_AT_TAIL;
                        state_in      = S_IDLE;
                     end else begin
                        hold_in  = rd_entry;
                        state_in = S_SWAP;
                     end
                  end
                  default: begin
                     // Cancel or serve: report now, then close the gap.
                     rsp_valid_in = 1'b1;
                     if (req_ff.cmd == CMD_SERVE) begin
                        rsp_in.ticket_out = rd_entry.ticket;
                        rsp_in.party_out  = rd_entry.party;
                     end
                     if (at_last) begin
                        cnt_in   = cnt_ff - CNT_W'(1);
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
               endcase
            end else begin
               sum_in = sum_ff + SUM_W'(rd_entry.party);
               if (at_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end else begin
                  scan_in = scan_p1[IDX_W-1:0];
               end
            end
         end

         S_SHIFT: begin
            // Read data holds entry scan_ff + 1; move it up by one place.
            ram_rd_addr = scan_p2[IDX_W-1:0];
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_ff;
            ram_wr_data = rd_entry;
            if (scan_p2 == cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_IDLE;
            end else begin
               scan_in = scan_p1[IDX_W-1:0];
            end
         end

         S_SWAP: begin
            // The entry behind moves forward into the delayed entry's place.
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_ff;
            ram_wr_data = rd_entry;
            state_in    = S_SWAP2;
         end

         S_SWAP2: begin
            // The delayed entry goes one place back.
            ram_wr_en    = 1'b1;
            ram_wr_addr  = scan_p1[IDX_W-1:0];
            ram_wr_data  = hold_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
